/* hw/rtl/jvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_pkg
// shared types and constants of the joystick velocity shaper
// ----------------------------------------------------------------------------
package jvs_pkg;

    localparam int USE_DPAD     = 0;
    localparam int STOP_REPEATS = 3;
    localparam int BUTTON_COUNT = 16;
    localparam int DIV_STEPS    = 16;   // two quotient bits per step

    localparam logic [14:0] DZ_CAP    = 15'd31129;
    localparam logic [9:0]  TICK_SAT  = 10'd1023;
    localparam logic [16:0] Q15_ONE   = 17'd32768;

    // register indexes
    localparam logic [2:0] REG_LINEAR_LIMIT   = 3'd0;
    localparam logic [2:0] REG_ANGULAR_LIMIT  = 3'd1;
    localparam logic [2:0] REG_DEADZONE_ENTER = 3'd2;
    localparam logic [2:0] REG_DZ_HYSTERESIS  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;
    localparam logic [2:0] REG_ACCEL_STEP     = 3'd5;
    localparam logic [2:0] REG_ALPHA_STEP     = 3'd6;
    localparam logic [2:0] REG_DEADMAN_SELECT = 3'd7;

    // axis slots of the shaping pass
    localparam logic [1:0] AX_FORWARD = 2'd0;
    localparam logic [1:0] AX_LATERAL = 2'd1;
    localparam logic [1:0] AX_YAW     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [14:0] linear_limit;
        logic [14:0] angular_limit;
        logic [14:0] deadzone_enter;
        logic [14:0] dz_hysteresis;
        logic [9:0]  timeout_ticks;
        logic [14:0] accel_step;
        logic [14:0] alpha_step;
        logic [4:0]  deadman_select;
    } t_cfg;

    typedef struct packed {
        logic       load_sample;
        logic       tick_check;
        logic       mul;
        logic       load_div;
        logic       div_step;
        logic       store;
        logic       finish;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic timed_out;
        logic shape_path;
        logic emit;
    } t_sts;

endpackage

/* hw/rtl/jvs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_in_if / jvs_out_if
// valid/ready channels for joystick items and velocity results
// ----------------------------------------------------------------------------
interface jvs_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_yaw;
    logic signed [15:0] dpad_x;
    logic signed [15:0] dpad_y;
    logic [15:0]        buttons;

    modport source (output valid, command, left_x, left_y, right_yaw, dpad_x, dpad_y,
                    buttons, input ready);
    modport sink   (input valid, command, left_x, left_y, right_yaw, dpad_x, dpad_y,
                    buttons, output ready);
endinterface

interface jvs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [15:0] yaw_rate;
    logic               forced_stop;

    modport source (output valid, vel_forward, vel_lateral, yaw_rate, forced_stop,
                    input ready);
    modport sink   (input valid, vel_forward, vel_lateral, yaw_rate, forced_stop,
                    output ready);
endinterface

/* hw/rtl/jvs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_cfg
// apb register file holding the shaper configuration
// ----------------------------------------------------------------------------
module jvs_cfg
    import jvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_limit   <= 15'd2048;
            r_cfg.angular_limit  <= 15'd2048;
            r_cfg.deadzone_enter <= 15'd4915;
            r_cfg.dz_hysteresis  <= 15'd655;
            r_cfg.timeout_ticks  <= 10'd15;
            r_cfg.accel_step     <= 15'd31;
            r_cfg.alpha_step     <= 15'd61;
            r_cfg.deadman_select <= 5'd0;
        end else if (w_wr) begin
            case (w_idx)
                REG_LINEAR_LIMIT:   r_cfg.linear_limit   <= pwdata[14:0];
                REG_ANGULAR_LIMIT:  r_cfg.angular_limit  <= pwdata[14:0];
                REG_DEADZONE_ENTER: r_cfg.deadzone_enter <= pwdata[14:0];
                REG_DZ_HYSTERESIS:  r_cfg.dz_hysteresis  <= pwdata[14:0];
                REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= pwdata[9:0];
                REG_ACCEL_STEP:     r_cfg.accel_step     <= pwdata[14:0];
                REG_ALPHA_STEP:     r_cfg.alpha_step     <= pwdata[14:0];
                REG_DEADMAN_SELECT: r_cfg.deadman_select <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LINEAR_LIMIT:   prdata = {17'd0, r_cfg.linear_limit};
            REG_ANGULAR_LIMIT:  prdata = {17'd0, r_cfg.angular_limit};
            REG_DEADZONE_ENTER: prdata = {17'd0, r_cfg.deadzone_enter};
            REG_DZ_HYSTERESIS:  prdata = {17'd0, r_cfg.dz_hysteresis};
            REG_TIMEOUT_TICKS:  prdata = {22'd0, r_cfg.timeout_ticks};
            REG_ACCEL_STEP:     prdata = {17'd0, r_cfg.accel_step};
            REG_ALPHA_STEP:     prdata = {17'd0, r_cfg.alpha_step};
            REG_DEADMAN_SELECT: prdata = {27'd0, r_cfg.deadman_select};
            default:            prdata = 32'd0;
        endcase
    end
endmodule

/* hw/rtl/jvs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_ctrl
// sequencer: sample store, tick check, per-axis shaping, slew, result beat
// ----------------------------------------------------------------------------
module jvs_ctrl
    import jvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [3:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AX_FORWARD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.is_tick) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_axis = AX_FORWARD;
                if (i_sts.timed_out)       n_state = S_OUT;
                else if (i_sts.shape_path) n_state = S_MUL;
                else                       n_state = S_FIN;
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) n_state = S_STORE;
            end
            S_STORE: begin
                n_axis = r_axis + 2'd1;
                if (r_axis == AX_YAW) n_state = S_FIN;
                else                  n_state = S_MUL;
            end
            S_FIN: begin
                if (i_sts.emit) n_state = S_OUT;
                else            n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid & ~i_sts.is_tick;
            end
            S_CHECK: o_cmd.tick_check = 1'b1;
            S_MUL:   o_cmd.mul        = 1'b1;
            S_LOAD:  o_cmd.load_div   = 1'b1;
            S_DIV:   o_cmd.div_step   = 1'b1;
            S_STORE: o_cmd.store      = 1'b1;
            S_FIN:   o_cmd.finish     = 1'b1;
            S_OUT:   o_out_valid      = 1'b1;
            default: ;
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output open together");
    a_timeout_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_sts.timed_out) |=> (r_state == S_OUT))
        else $error("watchdog stop did not go to output");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (r_state == S_IDLE))
        else $error("no return to idle after result beat");
endmodule

/* hw/rtl/jvs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_dp
// held sample, watchdog, deadzone shaping with radix-4 divider, clamp and slew
// ----------------------------------------------------------------------------
module jvs_dp
    import jvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic               i_command,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_yaw,
    input  logic signed [15:0] i_dpad_x,
    input  logic signed [15:0] i_dpad_y,
    input  logic [15:0]        i_buttons,
    output t_sts               o_sts,
    output logic signed [15:0] o_vel_forward,
    output logic signed [15:0] o_vel_lateral,
    output logic signed [15:0] o_yaw_rate,
    output logic               o_forced_stop
);
    logic signed [15:0] r_axes [5];
    logic [15:0]        r_buttons;
    logic               r_seen;
    logic [9:0]         r_ticks;
    logic [2:0]         r_flag;
    logic signed [15:0] r_cur [3];
    logic signed [15:0] r_tgt [3];
    logic [7:0]         r_zcnt;
    logic               r_stop;
    logic [29:0]        r_prod;
    logic [15:0]        r_den;
    logic               r_zero;
    logic               r_neg;
    logic [31:0]        r_num;
    logic [16:0]        r_rem;

    function automatic logic signed [15:0] axis_in(input logic signed [15:0] v);
        return (v == 16'sh8000) ? -16'sd32767 : v;
    endfunction

    function automatic logic [14:0] mag15(input logic signed [15:0] v);
        logic [15:0] a;
        a = v[15] ? 16'(-v) : 16'(v);
        return a[14:0];
    endfunction

    function automatic logic signed [15:0] apply_sign(input logic neg, input logic [14:0] m);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
                                                     input logic [14:0] lim);
        logic signed [15:0] l;
        l = $signed({1'b0, lim});
        if (v > l)       return l;
        else if (v < -l) return -l;
        else             return v;
    endfunction

    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [14:0] step);
        logic signed [16:0] d;
        logic signed [16:0] s;
        logic signed [16:0] r;
        d = 17'(tgt) - 17'(cur);
        s = $signed({2'b00, step});
        if (d > s)  d = s;
        if (d < -s) d = -s;
        r = 17'(cur) + d;
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] scale_direct(input logic signed [15:0] v,
                                                        input logic [14:0] lim);
        logic [29:0] p;
        logic [30:0] q;
        p = mag15(v) * lim;
        q = {1'b0, p} + 31'd16384;
        return apply_sign(v[15], q[29:15]);
    endfunction

    // ---- thresholds
    logic [14:0] w_enter, w_hyst, w_exit;
    assign w_enter = (i_cfg.deadzone_enter > DZ_CAP) ? DZ_CAP : i_cfg.deadzone_enter;
    assign w_hyst  = (i_cfg.dz_hysteresis > w_enter) ? w_enter : i_cfg.dz_hysteresis;
    assign w_exit  = w_enter - w_hyst;

    // ---- axis select for shaping
    logic signed [15:0] w_v;
    logic [14:0]        w_lim, w_m;
    logic               w_flag_old, w_flag_new;
    always_comb begin
        case (i_cmd.axis)
            AX_FORWARD: begin w_v = r_axes[1]; w_lim = i_cfg.linear_limit; end
            AX_LATERAL: begin w_v = r_axes[0]; w_lim = i_cfg.linear_limit; end
            default:    begin w_v = r_axes[2]; w_lim = i_cfg.angular_limit; end
        endcase
        w_m        = mag15(w_v);
        w_flag_old = r_flag[i_cmd.axis];
        if (!w_flag_old && w_m >= w_enter)    w_flag_new = 1'b1;
        else if (w_flag_old && w_m < w_exit)  w_flag_new = 1'b0;
        else                                  w_flag_new = w_flag_old;
    end

    // ---- two restoring divide steps per cycle
    logic [17:0] w_t1, w_t2;
    logic [16:0] w_r1, w_r2, w_d;
    logic        w_q1, w_q2;
    always_comb begin
        w_d  = {r_den, 1'b0};
        w_t1 = {r_rem, r_num[31]};
        w_q1 = (w_t1 >= {1'b0, w_d});
        w_r1 = w_q1 ? 17'(w_t1 - {1'b0, w_d}) : w_t1[16:0];
        w_t2 = {w_r1, r_num[30]};
        w_q2 = (w_t2 >= {1'b0, w_d});
        w_r2 = w_q2 ? 17'(w_t2 - {1'b0, w_d}) : w_t2[16:0];
    end

    // ---- watchdog and deadman
    logic       w_timed_out;
    logic [4:0] w_dm_k;
    logic       w_dm_held, w_dm_fail;
    assign w_timed_out = (i_cfg.timeout_ticks != 10'd0) && r_seen &&
                         (r_ticks >= i_cfg.timeout_ticks);
    assign w_dm_k      = i_cfg.deadman_select - 5'd1;
    assign w_dm_held   = r_seen && (32'(w_dm_k) < BUTTON_COUNT) && (w_dm_k < 5'd16) &&
                         r_buttons[w_dm_k[3:0]];
    assign w_dm_fail   = (i_cfg.deadman_select != 5'd0) && !w_dm_held;

    // ---- clamp and slew
    logic signed [15:0] w_ncur [3];
    logic               w_all_zero;
    always_comb begin
        w_ncur[0] = slew(r_cur[0], clamp_sym(r_tgt[0], i_cfg.linear_limit), i_cfg.accel_step);
        w_ncur[1] = slew(r_cur[1], clamp_sym(r_tgt[1], i_cfg.linear_limit), i_cfg.accel_step);
        w_ncur[2] = slew(r_cur[2], clamp_sym(r_tgt[2], i_cfg.angular_limit), i_cfg.alpha_step);
        w_all_zero = (w_ncur[0] == 16'sd0) && (w_ncur[1] == 16'sd0) && (w_ncur[2] == 16'sd0);
    end

    assign o_sts.is_tick    = i_command;
    assign o_sts.timed_out  = w_timed_out;
    assign o_sts.shape_path = r_seen && (USE_DPAD == 0);
    assign o_sts.emit       = w_dm_fail || !w_all_zero || (32'(r_zcnt) < STOP_REPEATS);

    logic signed [15:0] w_shaped;
    assign w_shaped = r_zero ? 16'sd0 : apply_sign(r_neg, r_num[14:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_axes[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
            r_buttons <= '0;
            r_seen    <= 1'b0;
            r_ticks   <= '0;
            r_flag    <= '0;
            r_zcnt    <= '0;
            r_stop    <= 1'b0;
        end else begin
            if (i_cmd.load_sample) begin
                r_axes[0] <= axis_in(i_left_x);
                r_axes[1] <= axis_in(i_left_y);
                r_axes[2] <= axis_in(i_right_yaw);
                r_axes[3] <= axis_in(i_dpad_x);
                r_axes[4] <= axis_in(i_dpad_y);
                r_buttons <= i_buttons;
                r_seen    <= 1'b1;
                r_ticks   <= '0;
            end
            if (i_cmd.tick_check) begin
                if (r_ticks < TICK_SAT) r_ticks <= r_ticks + 10'd1;
                if (w_timed_out) begin
                    for (int i = 0; i < 3; i++) r_cur[i] <= '0;
                    r_flag <= '0;
                    r_zcnt <= '0;
                    r_stop <= 1'b1;
                end else begin
                    r_stop <= 1'b0;
                    if (!r_seen) begin
                        r_flag <= '0;
                        for (int i = 0; i < 3; i++) r_tgt[i] <= '0;
                    end else if (USE_DPAD != 0) begin
                        r_tgt[0] <= scale_direct(r_axes[4], i_cfg.linear_limit);
                        r_tgt[1] <= scale_direct(r_axes[3], i_cfg.linear_limit);
                        if (r_buttons[2] && !r_buttons[1])
                            r_tgt[2] <= $signed({1'b0, i_cfg.angular_limit});
                        else if (r_buttons[1] && !r_buttons[2])
                            r_tgt[2] <= -$signed({1'b0, i_cfg.angular_limit});
                        else
                            r_tgt[2] <= 16'sd0;
                    end
                end
            end
            if (i_cmd.mul) r_flag[i_cmd.axis] <= w_flag_new;
            if (i_cmd.store) begin
                if (i_cmd.axis == AX_YAW) r_tgt[2] <= -w_shaped;
                else                      r_tgt[i_cmd.axis] <= w_shaped;
            end
            if (i_cmd.finish) begin
                if (w_dm_fail) begin
                    for (int i = 0; i < 3; i++) r_cur[i] <= '0;
                    r_flag <= '0;
                    r_zcnt <= '0;
                    r_stop <= 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) r_cur[i] <= w_ncur[i];
                    if (!w_all_zero)                        r_zcnt <= '0;
                    else if (32'(r_zcnt) < STOP_REPEATS)    r_zcnt <= r_zcnt + 8'd1;
                end
            end
        end
    end

    // payload of the shaping divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_zero <= !w_flag_new || (w_m < w_exit);
            r_neg  <= w_v[15];
            r_prod <= (w_m - w_exit) * w_lim;
            r_den  <= 16'(Q15_ONE - {2'b00, w_exit});
        end
        if (i_cmd.load_div) begin
            r_num <= {1'b0, r_prod, 1'b0} + {16'd0, r_den};
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[29:0], w_q1, w_q2};
            r_rem <= w_r2;
        end
    end

    assign o_vel_forward = r_cur[0];
    assign o_vel_lateral = r_cur[1];
    assign o_yaw_rate    = r_cur[2];
    assign o_forced_stop = r_stop;

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur[0] != 16'sh8000) && (r_cur[1] != 16'sh8000) && (r_cur[2] != 16'sh8000))
        else $error("output reached most negative code");
endmodule

/* hw/rtl/joystick_velocity_shaper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_velocity_shaper
// teleop joystick to velocity command shaper with deadzone, watchdog and slew
// ----------------------------------------------------------------------------
// usage:
//   i_in carries beats: command 0 stores a joystick sample (axes, buttons),
//   command 1 is a control tick that may produce one beat on o_out.
//   the apb port writes the eight configuration registers at 4*index; only
//   write it while the block is idle. pready is tied high.
// sequencing:
//   one beat is worked at a time. a sample is stored directly from idle. a tick
//   ends early when stopped by the watchdog or with no sample yet; in stick
//   mode three axes run through one shared divider that retires two quotient
//   bits a cycle, then clamp and slew are applied. the result is held on
//   o_out until it is taken.
// reset:
//   synchronous, active low; configuration returns to defaults, the held
//   sample, watchdog, deadzone flags, outputs and zero-repeat count clear.
// stall:
//   while o_out is not ready the result stays and i_in is not accepted.
// ----------------------------------------------------------------------------
module joystick_velocity_shaper
    import jvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    jvs_in_if.sink      i_in,
    jvs_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // register file
    jvs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer owns both handshakes
    jvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath; its output registers double as the result holding stage
    jvs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (w_cfg),
        .i_command     (i_in.command),
        .i_left_x      (i_in.left_x),
        .i_left_y      (i_in.left_y),
        .i_right_yaw   (i_in.right_yaw),
        .i_dpad_x      (i_in.dpad_x),
        .i_dpad_y      (i_in.dpad_y),
        .i_buttons     (i_in.buttons),
        .o_sts         (w_sts),
        .o_vel_forward (o_out.vel_forward),
        .o_vel_lateral (o_out.vel_lateral),
        .o_yaw_rate    (o_out.yaw_rate),
        .o_forced_stop (o_out.forced_stop)
    );
endmodule

/* verif/joystick_velocity_shaper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_velocity_shaper_tb
// drives samples and ticks through the valid/ready input, writes the config
// registers over apb while idle, predicts every velocity beat in a local
// model and compares each output beat field by field
// ----------------------------------------------------------------------------
module joystick_velocity_shaper_tb;
    import jvs_pkg::*;

    localparam bit TICK_CMD   = 1'b1;
    localparam bit SAMPLE_CMD = 1'b0;

    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] lat;
        logic signed [15:0] yaw;
        logic               stop;
    } t_vel;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    jvs_in_if  in_ch();
    jvs_out_if out_ch();

    joystick_velocity_shaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state: config mirror and shaper state
    int unsigned lin_lim, ang_lim, dz_enter, dz_hyst, tmo, acc_st, alp_st, dm_sel;
    int          axes_held[5];
    int unsigned btn_held;
    bit          have_sample;
    int unsigned ticks_idle;
    bit          active[3];
    int          vel_now[3];
    int unsigned zero_runs;

    t_vel expected_vel[$];
    bit   failed;

    // idling control: percent chance per cycle
    int unsigned send_gap_pct, recv_stall_pct;
    int unsigned hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic bit btn_on(int unsigned k);
        if (!have_sample || k >= BUTTON_COUNT || k >= 16) return 1'b0;
        return btn_held[k];
    endfunction

    function automatic int deadzone_shape(int idx, int v, int unsigned lim);
        int unsigned m, en, hy, ex;
        longint unsigned den, num;
        m  = (v < 0) ? -v : v;
        en = (dz_enter > DZ_CAP) ? DZ_CAP : dz_enter;
        hy = (dz_hyst > en) ? en : dz_hyst;
        ex = en - hy;
        if (!active[idx] && m >= en) active[idx] = 1'b1;
        else if (active[idx] && m < ex) active[idx] = 1'b0;
        if (!active[idx] || m < ex) return 0;
        den = 32768 - ex;
        num = longint'(m - ex) * lim;
        m = 32'((2 * num + den) / (2 * den));
        return (v < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic int scale_dir(int v, int unsigned lim);
        int unsigned m;
        longint unsigned p;
        m = (v < 0) ? -v : v;
        p = longint'(m) * lim;
        m = 32'((p + 16384) >> 15);
        return (v < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic int clamp_to(int v, int unsigned lim);
        int l;
        l = lim;
        return (v > l) ? l : ((v < -l) ? -l : v);
    endfunction

    function automatic int slew_toward(int cur, int tgt, int unsigned st);
        int d, s;
        d = tgt - cur;
        s = st;
        if (d > s) d = s;
        if (d < -s) d = -s;
        return cur + d;
    endfunction

    function automatic void push_vel(bit stop);
        t_vel r;
        r.fwd  = 16'(vel_now[0]);
        r.lat  = 16'(vel_now[1]);
        r.yaw  = 16'(vel_now[2]);
        r.stop = stop;
        expected_vel.push_back(r);
    endfunction

    function automatic void halt_outputs();
        for (int i = 0; i < 3; i++) begin
            active[i]  = 1'b0;
            vel_now[i] = 0;
        end
        zero_runs = 0;
        push_vel(1'b1);
    endfunction

    function automatic void predict_beat(bit cmd, logic [15:0] ax[5], logic [15:0] btn);
        int tf, tl, ty;
        bit timed_out;
        bit xb, bb;
        tf = 0; tl = 0; ty = 0;
        if (cmd == SAMPLE_CMD) begin
            for (int i = 0; i < 5; i++) begin
                axes_held[i] = $signed(ax[i]);
                if (axes_held[i] == -32768) axes_held[i] = -32767;
            end
            btn_held    = btn;
            have_sample = 1'b1;
            ticks_idle  = 0;
            return;
        end
        timed_out = (tmo != 0) && have_sample && (ticks_idle >= tmo);
        if (ticks_idle < TICK_SAT) ticks_idle++;
        if (timed_out) begin
            halt_outputs();
            return;
        end
        if (have_sample) begin
            if (USE_DPAD != 0) begin
                xb = btn_on(2);
                bb = btn_on(1);
                tf = scale_dir(axes_held[4], lin_lim);
                tl = scale_dir(axes_held[3], lin_lim);
                if (xb && !bb)      ty = int'(ang_lim);
                else if (bb && !xb) ty = -int'(ang_lim);
            end else begin
                tf = deadzone_shape(0, axes_held[1], lin_lim);
                tl = deadzone_shape(1, axes_held[0], lin_lim);
                ty = -deadzone_shape(2, axes_held[2], ang_lim);
            end
        end else begin
            for (int i = 0; i < 3; i++) active[i] = 1'b0;
        end
        if (dm_sel != 0 && !btn_on(dm_sel - 1)) begin
            halt_outputs();
            return;
        end
        vel_now[0] = slew_toward(vel_now[0], clamp_to(tf, lin_lim), acc_st);
        vel_now[1] = slew_toward(vel_now[1], clamp_to(tl, lin_lim), acc_st);
        vel_now[2] = slew_toward(vel_now[2], clamp_to(ty, ang_lim), alp_st);
        if (vel_now[0] == 0 && vel_now[1] == 0 && vel_now[2] == 0) begin
            if (zero_runs < STOP_REPEATS) begin
                zero_runs++;
                push_vel(1'b0);
            end
            return;
        end
        zero_runs = 0;
        push_vel(1'b0);
    endfunction

    // ---------------- drivers ----------------
    // drop valid, wait for every expected beat, then let a silent tick finish
    task automatic drain();
        int unsigned guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (expected_vel.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // a tick may still be at work without producing a beat
        repeat (80) @(posedge i_clk);
    endtask

    // register write only once the block has gone idle
    task automatic apb_write(logic [2:0] idx, int unsigned val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINEAR_LIMIT:   lin_lim  = val & 16'h7fff;
            REG_ANGULAR_LIMIT:  ang_lim  = val & 16'h7fff;
            REG_DEADZONE_ENTER: dz_enter = val & 16'h7fff;
            REG_DZ_HYSTERESIS:  dz_hyst  = val & 16'h7fff;
            REG_TIMEOUT_TICKS:  tmo      = val & 10'h3ff;
            REG_ACCEL_STEP:     acc_st   = val & 16'h7fff;
            REG_ALPHA_STEP:     alp_st   = val & 16'h7fff;
            REG_DEADMAN_SELECT: dm_sel   = val & 5'h1f;
            default: ;
        endcase
    endtask

    // one beat on the input channel; valid stays high across back-to-back beats
    task automatic send_beat(bit cmd, logic [15:0] ax[5], logic [15:0] btn);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.left_x    <= ax[0];
        in_ch.left_y    <= ax[1];
        in_ch.right_yaw <= ax[2];
        in_ch.dpad_x    <= ax[3];
        in_ch.dpad_y    <= ax[4];
        in_ch.buttons   <= btn;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_beat(cmd, ax, btn);
    endtask

    task automatic send_tick();
        logic [15:0] ax[5];
        foreach (ax[i]) ax[i] = 16'($urandom);
        send_beat(TICK_CMD, ax, 16'($urandom));
    endtask

    task automatic send_sample(int lx, int ly, int ry, logic [15:0] btn);
        logic [15:0] ax[5];
        ax[0] = 16'(lx); ax[1] = 16'(ly); ax[2] = 16'(ry);
        ax[3] = 16'($urandom); ax[4] = 16'($urandom);
        send_beat(SAMPLE_CMD, ax, btn);
    endtask

    // random axis value, biased toward the deadzone edges and the extremes
    function automatic int rand_axis();
        case ($urandom_range(5))
            0: return $urandom_range(65535) - 32768;
            1: return int'(dz_enter) + $urandom_range(200) - 100;
            2: return -(int'(dz_enter) + $urandom_range(200) - 100);
            3: return $urandom_range(1) ? 32767 : -32768;
            default: return $urandom_range(40000) - 20000;
        endcase
    endfunction

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_vel.size() == 0) begin
                    $display("%0t: unexpected beat fwd=%0d lat=%0d yaw=%0d stop=%0b", $time,
                             out_ch.vel_forward, out_ch.vel_lateral, out_ch.yaw_rate,
                             out_ch.forced_stop);
                    failed = 1'b1;
                end else begin
                    t_vel e;
                    e = expected_vel.pop_front();
                    if (e.fwd !== out_ch.vel_forward) begin
                        $display("%0t: vel_forward expected %0d actual %0d", $time, e.fwd,
                                 out_ch.vel_forward);
                        failed = 1'b1;
                    end
                    if (e.lat !== out_ch.vel_lateral) begin
                        $display("%0t: vel_lateral expected %0d actual %0d", $time, e.lat,
                                 out_ch.vel_lateral);
                        failed = 1'b1;
                    end
                    if (e.yaw !== out_ch.yaw_rate) begin
                        $display("%0t: yaw_rate expected %0d actual %0d", $time, e.yaw,
                                 out_ch.yaw_rate);
                        failed = 1'b1;
                    end
                    if (e.stop !== out_ch.forced_stop) begin
                        $display("%0t: forced_stop expected %0b actual %0b", $time, e.stop,
                                 out_ch.forced_stop);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // receiver ready: a long hold-off wins, else random stall
    always @(posedge i_clk) begin
        if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready    <= 1'b0;
        end else begin
            out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- tests ----------------
    task automatic reset_model();
        lin_lim = 2048; ang_lim = 2048; dz_enter = 4915; dz_hyst = 655;
        tmo = 15; acc_st = 31; alp_st = 61; dm_sel = 0;
        foreach (axes_held[i]) axes_held[i] = 0;
        btn_held = 0; have_sample = 0; ticks_idle = 0; zero_runs = 0;
        for (int i = 0; i < 3; i++) begin
            active[i] = 0; vel_now[i] = 0;
        end
    endtask

    // ticks before any sample, extremes of every axis, -32768 saturation
    task automatic test_directed();
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        apb_write(REG_ACCEL_STEP, 32767);
        apb_write(REG_ALPHA_STEP, 32767);
        apb_write(REG_LINEAR_LIMIT, 32767);
        apb_write(REG_ANGULAR_LIMIT, 32767);
        send_sample(-32768, -32768, -32768, 16'hffff);
        send_tick();
        send_sample(32767, 32767, 32767, 16'h0000);
        send_tick();
        send_sample(4915, -4915, 4914, 16'h5555);
        send_tick();
        send_sample(4300, 4259, -4260, 16'haaaa);
        send_tick();
        send_sample(0, 0, 0, 0);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        drain();
    endtask

    // watchdog expiry, deadman held / released / out of range
    task automatic test_watchdog_deadman();
        apb_write(REG_TIMEOUT_TICKS, 2);
        send_sample(20000, -20000, 20000, 16'h0001);
        repeat (5) send_tick();
        apb_write(REG_TIMEOUT_TICKS, 0);
        apb_write(REG_DEADMAN_SELECT, 1);
        send_sample(20000, 20000, -20000, 16'h0001);
        send_tick();
        send_sample(20000, 20000, -20000, 16'h0000);
        send_tick();
        apb_write(REG_DEADMAN_SELECT, 17);
        send_sample(20000, 20000, -20000, 16'hffff);
        send_tick();
        apb_write(REG_DEADMAN_SELECT, 16);
        send_sample(20000, 20000, -20000, 16'h8000);
        send_tick();
        drain();
    endtask

    // one random phase: mostly ticks on held samples, buttons random
    task automatic random_phase(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0)
                send_sample(rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
            else
                send_tick();
        end
        drain();
    endtask

    task automatic random_config(int unsigned variant);
        case (variant)
            0: begin
                apb_write(REG_LINEAR_LIMIT, 0);
                apb_write(REG_ANGULAR_LIMIT, 0);
                apb_write(REG_DEADZONE_ENTER, 0);
                apb_write(REG_DZ_HYSTERESIS, 0);
                apb_write(REG_ACCEL_STEP, 1);
                apb_write(REG_ALPHA_STEP, 1);
            end
            1: begin
                apb_write(REG_DEADZONE_ENTER, 32767);
                apb_write(REG_DZ_HYSTERESIS, 32767);
                apb_write(REG_LINEAR_LIMIT, 32767);
                apb_write(REG_ANGULAR_LIMIT, 32767);
                apb_write(REG_ACCEL_STEP, 32767);
                apb_write(REG_ALPHA_STEP, 32767);
                apb_write(REG_TIMEOUT_TICKS, 1023);
            end
            default: begin
                apb_write(REG_LINEAR_LIMIT, $urandom_range(32767));
                apb_write(REG_ANGULAR_LIMIT, $urandom_range(32767));
                apb_write(REG_DEADZONE_ENTER, $urandom_range(31129));
                apb_write(REG_DZ_HYSTERESIS, $urandom_range(8000));
                apb_write(REG_TIMEOUT_TICKS, $urandom_range(12));
                apb_write(REG_ACCEL_STEP, $urandom_range(1, 3000));
                apb_write(REG_ALPHA_STEP, $urandom_range(1, 3000));
            end
        endcase
        apb_write(REG_DEADMAN_SELECT, $urandom_range(3) == 0 ? $urandom_range(17) : 0);
    endtask

    task automatic test_random_idling();
        int unsigned gaps[4]   = '{0, 47, 0, 21};
        int unsigned stalls[4] = '{0, 0, 47, 21};
        for (int p = 0; p < 4; p++) begin
            send_gap_pct   = gaps[p];
            recv_stall_pct = stalls[p];
            random_config(p);
            random_phase(150);
        end
        send_gap_pct   = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while ticks keep coming, so the block backs up
    task automatic test_backpressure();
        apb_write(REG_DEADMAN_SELECT, 0);
        apb_write(REG_TIMEOUT_TICKS, 0);
        send_sample(30000, -30000, 30000, 0);
        hold_off_cycles = 400;
        repeat (12) send_tick();
        drain();
    endtask

    initial begin
        failed          = 1'b0;
        send_gap_pct    = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.command = 1'b0;
        in_ch.left_x = '0; in_ch.left_y = '0; in_ch.right_yaw = '0;
        in_ch.dpad_x = '0; in_ch.dpad_y = '0; in_ch.buttons = '0;
        out_ch.ready = 1'b0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_watchdog_deadman();
        test_random_idling();
        test_backpressure();

        if (!failed && expected_vel.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
